/* rtl/lmf_pkg.sv */
// Shared constants, register codes and the pipeline token type of the flanger.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps

package lmf_pkg;

    localparam int DELAY_DEPTH     = 256;
    localparam int SINE_TABLE_SIZE = 1024;

    localparam int PTR_W     = $clog2(DELAY_DEPTH);
    localparam int CNT_W     = $clog2(DELAY_DEPTH + 1);
    localparam int SINE_BITS = $clog2(SINE_TABLE_SIZE);

    localparam int SMP_W   = 16;
    localparam int BASE_W  = 7;
    localparam int PHASE_W = 32;
    localparam int GAIN_W  = 16;
    localparam int DLY_W   = BASE_W + 1;
    localparam int Q_W     = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN   = 2'd2;

    localparam logic [BASE_W-1:0]         BASE_DELAY_RST = 7'd11;
    localparam logic [PHASE_W-1:0]        PHASE_STEP_RST = 32'd779133;
    localparam logic signed [GAIN_W-1:0]  WET_GAIN_RST   = 16'sd26214;

    // sine polynomial coefficients, Q15
    localparam logic [Q_W-1:0] SINE_C0 = 16'd2320;
    localparam logic [Q_W-1:0] SINE_C1 = 16'd21024;
    localparam logic [Q_W-1:0] SINE_C2 = 16'd51472;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic [PTR_W-1:0]        wptr;
        logic [CNT_W-1:0]        seen;
        logic                    neg;
        logic [Q_W-1:0]          x;
        logic [Q_W-1:0]          x2;
        logic [Q_W-1:0]          t;
        logic signed [Q_W-1:0]   s;
        logic [DLY_W-1:0]        d;
    } lmf_tok_t;

endpackage

/* rtl/lmf_horner_cell.sv */
// One Horner step of the sine polynomial: t <= coef - (t * x2) >> 15.
// Depends on lmf_pkg; cells are chained with a valid/ready hand-off.
`timescale 1ns / 1ps

module lmf_horner_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  logic [lmf_pkg::Q_W-1:0] coef,
    input  lmf_pkg::lmf_tok_t    in_tok,
    output lmf_pkg::lmf_tok_t    out_tok
);

    logic                vld_reg;
    lmf_pkg::lmf_tok_t   tok_reg;
    lmf_pkg::lmf_tok_t   tok_next;
    logic [2*lmf_pkg::Q_W-1:0] prod;

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_tok   = tok_reg;

    always_comb
    begin
        tok_next   = in_tok;
        prod       = in_tok.t * in_tok.x2;
        tok_next.t = coef - prod[2*lmf_pkg::Q_W-2:lmf_pkg::Q_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            tok_reg <= tok_next;
        end
    end

endmodule

/* rtl/lmf_delay_mem.sv */
// Circular sample store: one write port, one read port with registered data.
// Depends on lmf_pkg for depth and sample width.
`timescale 1ns / 1ps

module lmf_delay_mem
(
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [lmf_pkg::PTR_W-1:0]         wr_addr,
    input  logic signed [lmf_pkg::SMP_W-1:0]  wr_data,
    input  logic                              rd_en,
    input  logic [lmf_pkg::PTR_W-1:0]         rd_addr,
    output logic signed [lmf_pkg::SMP_W-1:0]  rd_data
);

    logic signed [lmf_pkg::SMP_W-1:0] mem [lmf_pkg::DELAY_DEPTH];
    logic signed [lmf_pkg::SMP_W-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

/* rtl/lfo_modulated_flanger.sv */
// Flanger top level: sine LFO pipeline, delay store and wet mix.
// Throughput: one sample per cycle while m_axis_tready does not stall the output.
// Each stage holds one sample; the delay store is written and read in the same stage.
// Reset (rst_n low, asynchronous): pipeline empty, phase, write pointer, sample count zero,
// registers to defaults; store contents are not cleared.
// Depends on lmf_pkg, lmf_horner_cell, lmf_delay_mem.
`timescale 1ns / 1ps

module lfo_modulated_flanger
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lmf_pkg::SMP_W-1:0]           s_axis_tdata,  // [15:0] sample_in
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [lmf_pkg::SMP_W-1:0]           m_axis_tdata,  // [15:0] sample_out
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lmf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lmf_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int IDX_W = ((lmf_pkg::PTR_W > lmf_pkg::DLY_W) ?
                            lmf_pkg::PTR_W : lmf_pkg::DLY_W) + 1;
    localparam int SMP_W = lmf_pkg::SMP_W;
    localparam int Q_W   = lmf_pkg::Q_W;

    // configuration
    logic [lmf_pkg::BASE_W-1:0]         base_delay_reg;
    logic [lmf_pkg::PHASE_W-1:0]        phase_step_reg;
    logic signed [lmf_pkg::GAIN_W-1:0]  wet_gain_reg;

    // stream state
    logic [lmf_pkg::PHASE_W-1:0]  phase_reg;
    logic [lmf_pkg::PTR_W-1:0]    wptr_reg;
    logic [lmf_pkg::CNT_W-1:0]    seen_reg;

    // pipeline
    logic s0_vld_reg, s1_vld_reg, s2_vld, s3_vld, s4_vld_reg, s5_vld_reg;
    logic s6_vld_reg, s7_vld_reg;
    logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;
    lmf_pkg::lmf_tok_t s0_tok_reg, s0_tok_next;
    lmf_pkg::lmf_tok_t s1_tok_reg, s1_tok_next;
    lmf_pkg::lmf_tok_t s2_tok, s3_tok;
    lmf_pkg::lmf_tok_t s4_tok_reg, s4_tok_next;
    lmf_pkg::lmf_tok_t s5_tok_reg, s5_tok_next;

    logic signed [SMP_W-1:0] s6_sample_reg;
    logic                    s6_wet_reg;
    logic                    s6_byp_reg;
    logic [SMP_W-1:0]        out_reg, out_next;

    logic acc;

    // stage 0 signals
    logic [lmf_pkg::SINE_BITS-1:0] k;
    logic [Q_W-1:0]                u;
    logic [Q_W-2:0]                r;

    // stage 1/4/5 arithmetic
    logic [2*Q_W-1:0]                  sq_prod;
    logic [2*Q_W-1:0]                  y_prod;
    logic [Q_W:0]                      y_full;
    logic [Q_W-2:0]                    y_sat;
    logic [Q_W-1:0]                    ofs;
    logic [lmf_pkg::BASE_W+Q_W-1:0]    d_prod;

    // memory stage
    logic                            load6;
    logic [IDX_W-1:0]                wp_e, d_e, seen_e, idx;
    logic signed [SMP_W-1:0]         mem_rd_data;

    // mix stage
    logic signed [SMP_W-1:0]         past;
    logic signed [2*SMP_W-1:0]       wprod;
    logic signed [SMP_W:0]           wet;
    logic signed [SMP_W+1:0]         mix;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_delay_reg <= lmf_pkg::BASE_DELAY_RST;
            phase_step_reg <= lmf_pkg::PHASE_STEP_RST;
            wet_gain_reg   <= lmf_pkg::WET_GAIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lmf_pkg::CFG_BASE_DELAY: base_delay_reg <= cfg_data[lmf_pkg::BASE_W-1:0];
                lmf_pkg::CFG_PHASE_STEP: phase_step_reg <= cfg_data[lmf_pkg::PHASE_W-1:0];
                lmf_pkg::CFG_WET_GAIN:   wet_gain_reg   <= cfg_data[lmf_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // ready chain
    assign rdy7 = !s7_vld_reg || m_axis_tready;
    assign rdy6 = !s6_vld_reg || rdy7;
    assign rdy5 = !s5_vld_reg || rdy6;
    assign rdy4 = !s4_vld_reg || rdy5;
    assign rdy1 = !s1_vld_reg || rdy2;
    assign rdy0 = !s0_vld_reg || rdy1;

    assign s_axis_tready = rdy0;
    assign acc           = s_axis_tvalid && s_axis_tready;

    // stage 0: take the sample, fold the phase into the first quadrant
    always_comb
    begin
        k = phase_reg[lmf_pkg::PHASE_W-1 -: lmf_pkg::SINE_BITS];
        u = {k, {(Q_W - lmf_pkg::SINE_BITS){1'b0}}};
        r = {u[Q_W-3:0], 1'b0};
        s0_tok_next        = '0;
        s0_tok_next.sample = s_axis_tdata;
        s0_tok_next.wptr   = wptr_reg;
        s0_tok_next.seen   = seen_reg;
        s0_tok_next.neg    = u[Q_W-1];
        s0_tok_next.x      = u[Q_W-2] ? (16'h8000 - {1'b0, r}) : {1'b0, r};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            wptr_reg  <= '0;
            seen_reg  <= '0;
        end
        else if (acc)
        begin
            phase_reg <= phase_reg + phase_step_reg;
            wptr_reg  <= (wptr_reg == lmf_pkg::PTR_W'(lmf_pkg::DELAY_DEPTH - 1)) ?
                         '0 : wptr_reg + 1'b1;
            if (seen_reg < lmf_pkg::CNT_W'(lmf_pkg::DELAY_DEPTH))
            begin
                seen_reg <= seen_reg + 1'b1;
            end
        end
    end

    // stage 1: x^2
    always_comb
    begin
        sq_prod        = s0_tok_reg.x * s0_tok_reg.x;
        s1_tok_next    = s0_tok_reg;
        s1_tok_next.x2 = sq_prod[2*Q_W-2:Q_W-1];
        s1_tok_next.t  = lmf_pkg::SINE_C0;
    end

    // stage 4: y = t * x, saturate, apply sign
    always_comb
    begin
        y_prod        = s3_tok.t * s3_tok.x;
        y_full        = y_prod[2*Q_W-1:Q_W-1];
        y_sat         = (y_full > 17'd32767) ? 15'h7FFF : y_full[Q_W-2:0];
        s4_tok_next   = s3_tok;
        s4_tok_next.s = s3_tok.neg ? -$signed({1'b0, y_sat}) : $signed({1'b0, y_sat});
    end

    // stage 5: d = base * (1 + s)
    always_comb
    begin
        ofs           = s4_tok_reg.s ^ 16'h8000;
        d_prod        = base_delay_reg * ofs;
        s5_tok_next   = s4_tok_reg;
        s5_tok_next.d = d_prod[lmf_pkg::BASE_W+Q_W-1:Q_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
        end
        else
        begin
            if (rdy0) s0_vld_reg <= s_axis_tvalid;
            if (rdy1) s1_vld_reg <= s0_vld_reg;
            if (rdy4) s4_vld_reg <= s3_vld;
            if (rdy5) s5_vld_reg <= s4_vld_reg;
            if (rdy6) s6_vld_reg <= s5_vld_reg;
            if (rdy7) s7_vld_reg <= s6_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)                     s0_tok_reg <= s0_tok_next;
        if (rdy1 && s0_vld_reg)      s1_tok_reg <= s1_tok_next;
        if (rdy4 && s3_vld)          s4_tok_reg <= s4_tok_next;
        if (rdy5 && s4_vld_reg)      s5_tok_reg <= s5_tok_next;
    end

    lmf_horner_cell u_cell1
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_vld_reg),
        .in_ready  (rdy2),
        .out_valid (s2_vld),
        .out_ready (rdy3),
        .coef      (lmf_pkg::SINE_C1),
        .in_tok    (s1_tok_reg),
        .out_tok   (s2_tok)
    );

    lmf_horner_cell u_cell2
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_vld),
        .in_ready  (rdy3),
        .out_valid (s3_vld),
        .out_ready (rdy4),
        .coef      (lmf_pkg::SINE_C2),
        .in_tok    (s2_tok),
        .out_tok   (s3_tok)
    );

    // stage 6: store current sample, read the delayed one
    assign load6  = s5_vld_reg && rdy6;
    assign wp_e   = IDX_W'(s5_tok_reg.wptr);
    assign d_e    = IDX_W'(s5_tok_reg.d);
    assign seen_e = IDX_W'(s5_tok_reg.seen);
    assign idx    = (wp_e >= d_e) ? (wp_e - d_e)
                                  : (wp_e + IDX_W'(lmf_pkg::DELAY_DEPTH) - d_e);

    lmf_delay_mem u_mem
    (
        .clk     (clk),
        .wr_en   (load6),
        .wr_addr (s5_tok_reg.wptr),
        .wr_data (s5_tok_reg.sample),
        .rd_en   (load6),
        .rd_addr (idx[lmf_pkg::PTR_W-1:0]),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (load6)
        begin
            s6_sample_reg <= s5_tok_reg.sample;
            s6_wet_reg    <= seen_e > d_e;
            s6_byp_reg    <= (s5_tok_reg.d == '0);
        end
    end

    // stage 7: wet mix and saturation
    always_comb
    begin
        past  = s6_byp_reg ? s6_sample_reg : mem_rd_data;
        wprod = wet_gain_reg * past;
        wet   = wprod[2*SMP_W-1:SMP_W-1];
        mix   = {{2{s6_sample_reg[SMP_W-1]}}, s6_sample_reg} + {wet[SMP_W], wet};
        if (!s6_wet_reg)
        begin
            out_next = s6_sample_reg;
        end
        else if (mix > 18'sd32767)
        begin
            out_next = 16'h7FFF;
        end
        else if (mix < -18'sd32768)
        begin
            out_next = 16'h8000;
        end
        else
        begin
            out_next = mix[SMP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy7 && s6_vld_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = s7_vld_reg;
    assign m_axis_tdata  = out_reg;

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= lmf_pkg::CNT_W'(lmf_pkg::DELAY_DEPTH))
        else $error("sample count past store depth");

    a_wptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, wptr_reg} < (lmf_pkg::PTR_W + 1)'(lmf_pkg::DELAY_DEPTH))
        else $error("write pointer out of range");

    a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> phase_reg == $past(phase_reg + phase_step_reg))
        else $error("phase did not advance by one step");

    a_s0_load: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> s0_vld_reg)
        else $error("accepted transfer lost at stage 0");

    a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s6_vld_reg && !rdy7 |-> !load6)
        else $error("delay store read while stalled");

endmodule

/* dv/tb_lfo_modulated_flanger.sv */
// Self-checking testbench for lfo_modulated_flanger: directed table, then random phases.
// Results are checked against expected values in the table or an in-bench predictor of the sine LFO and delay line.
// Depends on lmf_pkg and rtl/lfo_modulated_flanger.sv.
`timescale 1ns / 1ps

module tb_lfo_modulated_flanger;

    localparam int    CYCLE_LIMIT    = 400000;
    localparam int    DRAIN_CYCLES   = 16;
    localparam int    RANDOM_PHASES  = 10;
    localparam int    PHASE_ITEMS    = 115;
    localparam int    MAX_REPORTS    = 10;
    localparam logic [lmf_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef enum logic { ROW_SAMPLE, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t                          kind;
        logic [lmf_pkg::CFG_IDX_W-1:0]      idx;
        logic [lmf_pkg::CFG_DATA_W-1:0]     data;
        bit                                 typed;
        logic [lmf_pkg::SMP_W-1:0]          typed_out;
    } stim_row_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [lmf_pkg::SMP_W-1:0]          s_axis_tdata = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b1;
    logic [lmf_pkg::SMP_W-1:0]          m_axis_tdata;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [lmf_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [lmf_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

    // predictor state
    logic [lmf_pkg::BASE_W-1:0]         mirror_base;
    logic [lmf_pkg::PHASE_W-1:0]        mirror_step;
    logic signed [lmf_pkg::GAIN_W-1:0]  mirror_gain;
    logic signed [lmf_pkg::SMP_W-1:0]   hist [lmf_pkg::DELAY_DEPTH];
    int unsigned                        hist_wp;
    int unsigned                        hist_seen;
    logic [lmf_pkg::PHASE_W-1:0]        lfo_acc;

    logic [lmf_pkg::SMP_W-1:0]  expected_q [$];
    stim_row_t                  stim_rows [$];
    bit                         src_idle_en = 1'b0;
    bit                         snk_idle_en = 1'b0;
    int                         error_count = 0;
    int                         result_count = 0;
    int                         tick_count = 0;

    lfo_modulated_flanger DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int lfo_sine(input int unsigned k);
        int unsigned u;
        int unsigned quad;
        int unsigned r;
        int unsigned x;
        int unsigned x2;
        int unsigned t;
        longint unsigned y;
        u = ((k << 16) / lmf_pkg::SINE_TABLE_SIZE) & 32'hFFFF;
        quad = u >> 14;
        r = (u & 32'h3FFF) << 1;
        x = quad[0] ? (32'd32768 - r) : r;
        x2 = (x * x) >> 15;
        t = 32'd21024 - ((32'd2320 * x2) >> 15);
        t = 32'd51472 - ((t * x2) >> 15);
        y = ({32'd0, t} * {32'd0, x}) >> 15;
        if (y > 64'd32767)
            y = 64'd32767;
        return quad[1] ? -int'(y) : int'(y);
    endfunction

    function automatic logic [lmf_pkg::SMP_W-1:0] flanger_predict(
        input logic [lmf_pkg::SMP_W-1:0] smp);
        int x;
        int s;
        int past;
        int y;
        int unsigned k;
        int unsigned d;
        int unsigned idx;
        x = int'($signed(smp));
        k = int'(({32'd0, lfo_acc} * lmf_pkg::SINE_TABLE_SIZE) >> 32);
        s = lfo_sine(k);
        d = (int'(mirror_base) * (32768 + s)) >> 15;
        hist[hist_wp[lmf_pkg::PTR_W-1:0]] = smp;
        y = x;
        if (hist_seen > d && d < lmf_pkg::DELAY_DEPTH)
        begin
            idx = (hist_wp + lmf_pkg::DELAY_DEPTH - d) % lmf_pkg::DELAY_DEPTH;
            past = int'(hist[idx[lmf_pkg::PTR_W-1:0]]);
            y = x + ((int'(mirror_gain) * past) >>> 15);
            if (y > 32767)
                y = 32767;
            if (y < -32768)
                y = -32768;
        end
        hist_wp = (hist_wp + 1) % lmf_pkg::DELAY_DEPTH;
        if (hist_seen < lmf_pkg::DELAY_DEPTH)
            hist_seen = hist_seen + 1;
        lfo_acc = lfo_acc + mirror_step;
        return y[lmf_pkg::SMP_W-1:0];
    endfunction

    function automatic void add_row(input row_kind_t kind,
                                    input logic [lmf_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [lmf_pkg::CFG_DATA_W-1:0] data,
                                    input bit typed,
                                    input logic [lmf_pkg::SMP_W-1:0] typed_out);
        stim_row_t row;
        row.kind      = kind;
        row.idx       = idx;
        row.data      = data;
        row.typed     = typed;
        row.typed_out = typed_out;
        stim_rows.push_back(row);
    endfunction

    task automatic send_sample(input logic [lmf_pkg::SMP_W-1:0] smp, input bit typed,
                               input logic [lmf_pkg::SMP_W-1:0] typed_out);
        int gap;
        logic [lmf_pkg::SMP_W-1:0] pred;
        cfg_valid <= 1'b0;
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        do @(posedge clk); while (!s_axis_tready);
        pred = flanger_predict(smp);
        expected_q.push_back(typed ? typed_out : pred);
    endtask

    // cfg_valid is left high after the write; the next send_sample drops it
    task automatic put_reg(input logic [lmf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lmf_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            lmf_pkg::CFG_BASE_DELAY: mirror_base = val[lmf_pkg::BASE_W-1:0];
            lmf_pkg::CFG_PHASE_STEP: mirror_step = val[lmf_pkg::PHASE_W-1:0];
            lmf_pkg::CFG_WET_GAIN:   mirror_gain = val[lmf_pkg::GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        tick_count <= tick_count + 1;
        if (tick_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            result_count <= result_count + 1;
            if (expected_q.size() == 0)
            begin
                if (error_count < MAX_REPORTS)
                    $display("result %0d: unexpected transfer, actual %h",
                             result_count, m_axis_tdata);
                error_count <= error_count + 1;
            end
            else if (m_axis_tdata !== expected_q[0])
            begin
                if (error_count < MAX_REPORTS)
                    $display("result %0d: sample_out expected %h, actual %h",
                             result_count, expected_q[0], m_axis_tdata);
                error_count <= error_count + 1;
                void'(expected_q.pop_front());
            end
            else
                void'(expected_q.pop_front());
        end
    end

    initial
    begin
        int gap;
        forever
        begin
            if (snk_idle_en && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 15);
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int i;
        int n;
        bit prev_cfg;
        logic [lmf_pkg::SMP_W-1:0] smp;
        logic [lmf_pkg::BASE_W-1:0] base_val;
        logic [lmf_pkg::PHASE_W-1:0] step_val;
        logic [lmf_pkg::GAIN_W-1:0] gain_val;

        mirror_base = lmf_pkg::BASE_DELAY_RST;
        mirror_step = lmf_pkg::PHASE_STEP_RST;
        mirror_gain = lmf_pkg::WET_GAIN_RST;
        hist_wp     = 0;
        hist_seen   = 0;
        lfo_acc     = '0;
        for (i = 0; i < lmf_pkg::DELAY_DEPTH; i++)
            hist[i[lmf_pkg::PTR_W-1:0]] = '0;

        // after reset: too few samples for the delay tap, so the first outputs are dry
        add_row(ROW_SAMPLE, '0, 32'h0000_7FFF, 1'b1, 16'h7FFF);
        add_row(ROW_SAMPLE, '0, 32'h0000_8000, 1'b1, 16'h8000);
        add_row(ROW_SAMPLE, '0, 32'h0000_0000, 1'b1, 16'h0000);
        add_row(ROW_SAMPLE, '0, 32'h0000_0001, 1'b1, 16'h0001);
        add_row(ROW_SAMPLE, '0, 32'h0000_FFFF, 1'b1, 16'hFFFF);
        add_row(ROW_SAMPLE, '0, 32'h0000_5555, 1'b1, 16'h5555);
        add_row(ROW_SAMPLE, '0, 32'h0000_AAAA, 1'b1, 16'hAAAA);
        add_row(ROW_SAMPLE, '0, 32'h0000_1234, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 32'h0000_EDCB, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 32'h0000_7FFF, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 32'h0000_8000, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 32'h0000_4000, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 32'h0000_C000, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 32'h0000_0FFF, 1'b0, '0);
        // zero delay taps the current sample; full gain saturates both ways
        add_row(ROW_CFG, lmf_pkg::CFG_BASE_DELAY, 32'd0, 1'b0, '0);
        add_row(ROW_CFG, lmf_pkg::CFG_PHASE_STEP, 32'h8000_0000, 1'b0, '0);
        add_row(ROW_CFG, lmf_pkg::CFG_WET_GAIN, 32'h0000_7FFF, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 32'h0000_7FFF, 1'b1, 16'h7FFF);
        add_row(ROW_SAMPLE, '0, 32'h0000_8000, 1'b1, 16'h8000);
        // most negative gain cancels the sample
        add_row(ROW_CFG, lmf_pkg::CFG_WET_GAIN, 32'h0000_8000, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 32'h0000_8000, 1'b1, 16'h0000);
        add_row(ROW_SAMPLE, '0, 32'h0000_7FFF, 1'b1, 16'h0000);
        // longest delay, frozen LFO, write to an unused index is ignored
        add_row(ROW_CFG, lmf_pkg::CFG_BASE_DELAY, 32'd127, 1'b0, '0);
        add_row(ROW_CFG, lmf_pkg::CFG_PHASE_STEP, 32'd0, 1'b0, '0);
        add_row(ROW_CFG, CFG_UNUSED_IDX, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 32'h0000_0001, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 32'h0000_8000, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 32'h0000_7FFF, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 32'h0000_FFFF, 1'b0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        prev_cfg = 1'b1;
        foreach (stim_rows[r])
        begin
            if (stim_rows[r].kind == ROW_CFG)
            begin
                if (!prev_cfg)
                    wait_idle();
                put_reg(stim_rows[r].idx, stim_rows[r].data);
                prev_cfg = 1'b1;
            end
            else
            begin
                send_sample(stim_rows[r].data[lmf_pkg::SMP_W-1:0], stim_rows[r].typed,
                            stim_rows[r].typed_out);
                prev_cfg = 1'b0;
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_idle();
            case ($urandom_range(0, 3))
                0:       base_val = '0;
                1:       base_val = 7'd127;
                default: base_val = lmf_pkg::BASE_W'($urandom_range(0, 127));
            endcase
            case ($urandom_range(0, 4))
                0:       step_val = '0;
                1:       step_val = 32'h8000_0000;
                2:       step_val = $urandom_range(0, 32'h0010_0000);
                3:       step_val = $urandom_range(0, 32'h0400_0000);
                default: step_val = $urandom_range(0, 32'h8000_0000);
            endcase
            case ($urandom_range(0, 3))
                0:       gain_val = 16'h8000;
                1:       gain_val = 16'h7FFF;
                default: gain_val = lmf_pkg::GAIN_W'($urandom_range(0, 16'hFFFF));
            endcase
            put_reg(lmf_pkg::CFG_BASE_DELAY, {25'd0, base_val});
            put_reg(lmf_pkg::CFG_PHASE_STEP, step_val);
            put_reg(lmf_pkg::CFG_WET_GAIN, {16'd0, gain_val});
            if ($urandom_range(0, 3) == 0)
                put_reg(CFG_UNUSED_IDX, $urandom());

            src_idle_en = (ph != 3) && (ph != RANDOM_PHASES - 1);
            snk_idle_en = src_idle_en;
            n = PHASE_ITEMS;
            for (i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 9))
                    0:       smp = 16'h7FFF;
                    1:       smp = 16'h8000;
                    2:       smp = lmf_pkg::SMP_W'($urandom_range(0, 1) ?
                                                   $urandom_range(0, 255) :
                                                   -$urandom_range(0, 255));
                    default: smp = lmf_pkg::SMP_W'($urandom_range(0, 16'hFFFF));
                endcase
                send_sample(smp, 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
